// File: hw/rtl/lmtd_pkg.sv
// ----------------------------------------------------------------------------
// Line maze turn decider package
// Shared transaction types, field widths, decision and opcode codes.
// ----------------------------------------------------------------------------
package lmtd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int TIME_W       = 32;
  localparam int TIMEOUT_W    = 16;
  localparam int INDEX_W      = 8;
  localparam int CODE_W       = 3;
  localparam int PATH_LEN_W   = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam int PATH_DEPTH_DEFAULT = 256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_TIMEOUT_MS = 1'd1;

  localparam logic [SAMPLE_W-1:0]  DARK_THRESHOLD_RESET  = 12'd2048;
  localparam logic [TIMEOUT_W-1:0] GOAL_TIMEOUT_MS_RESET = 16'd500;

  // Opcodes.
  localparam logic OP_SENSE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Decision codes, also used for stored turns.
  localparam logic [CODE_W-1:0] DEC_CHECKING = 3'd0;
  localparam logic [CODE_W-1:0] DEC_STRAIGHT = 3'd1;
  localparam logic [CODE_W-1:0] DEC_LEFT     = 3'd2;
  localparam logic [CODE_W-1:0] DEC_RIGHT    = 3'd3;
  localparam logic [CODE_W-1:0] DEC_DEAD_END = 3'd4;
  localparam logic [CODE_W-1:0] DEC_GOAL     = 3'd5;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sensor_0;
    logic [SAMPLE_W-1:0] sensor_1;
    logic [SAMPLE_W-1:0] sensor_2;
    logic [SAMPLE_W-1:0] sensor_3;
    logic [SAMPLE_W-1:0] sensor_4;
    logic [SAMPLE_W-1:0] sensor_5;
    logic [TIME_W-1:0]   time_ms;
    logic [INDEX_W-1:0]  read_index;
  } lmtd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]     decision;
    logic [CODE_W-1:0]     read_entry;
    logic [PATH_LEN_W-1:0] path_length;
    logic                  path_overflow;
  } lmtd_out_t;

endpackage

// File: hw/rtl/line_maze_turn_decider.sv
// ----------------------------------------------------------------------------
// Line maze turn decider
// Left-hand-rule crossing classifier with a path store of recorded turns.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload     Direction
//  -------  ---------------------  ----------  ---------
//  in       in_valid / in_stall    lmtd_in_t   into block
//  out      out_valid / out_stall  lmtd_out_t  out of block
//  cfg      cfg_valid / cfg_ready  index, data into block
//
// Every input transaction produces exactly one result transaction. The block
// has two register stages: an input register and a result register. The
// result register loads from the input register once it is empty or being
// drained, and one transaction per cycle is sustained while out_stall stays
// low. The path store read for a read opcode is issued when the transaction
// is accepted; a turn written in the same cycle is forwarded.
// Reset (rst, synchronous) clears the crossing flags, the path count and the
// overflow flag, and returns both configuration registers to their reset
// values; the path store contents are not cleared, since only entries below
// the count are ever returned.
// A stalled result holds in the result register, and the input register can
// still take one more transaction before in_stall rises.
// ----------------------------------------------------------------------------
module line_maze_turn_decider #(
  parameter int PATH_DEPTH = lmtd_pkg::PATH_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lmtd_pkg::lmtd_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lmtd_pkg::lmtd_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmtd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import lmtd_pkg::*;

  // Address width of the store, width of the turn count (holds PATH_DEPTH
  // itself), and a common width for comparing a read index with the count.
  localparam int AW    = $clog2(PATH_DEPTH);
  localparam int CW    = $clog2(PATH_DEPTH + 1);
  localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

  // Configuration registers. Writes are always taken.
  logic [SAMPLE_W-1:0]  dark_threshold;
  logic [TIMEOUT_W-1:0] goal_timeout_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold  <= DARK_THRESHOLD_RESET;
      goal_timeout_ms <= GOAL_TIMEOUT_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DARK_THRESHOLD:  dark_threshold  <= cfg_data[SAMPLE_W-1:0];
        REG_GOAL_TIMEOUT_MS: goal_timeout_ms <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the result register. The input
  // register moves on whenever the result register is empty or being drained.
  logic     a_valid;
  lmtd_in_t a_item;
  logic     a_advance;
  logic     in_fire;
  logic     a_fire;

  assign a_advance = !out_valid || !out_stall;
  assign in_stall  = a_valid && !a_advance;
  assign in_fire   = in_valid && !in_stall;
  assign a_fire    = a_valid && a_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_item <= in_data;
    end
  end

  // Crossing state.
  logic              checking_crossing, checking_crossing_next;
  logic              left_branch_seen, left_branch_seen_next;
  logic              right_branch_seen, right_branch_seen_next;
  logic [TIME_W-1:0] crossing_start_ms, crossing_start_ms_next;
  logic [CW-1:0]     stored_count, stored_count_next;
  logic              overflow_flag, overflow_flag_next;

  // Path store port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  // Forwarding of a turn written in the same cycle that a read was issued.
  logic              fwd_hit;
  logic [CODE_W-1:0] fwd_data;

  assign ram_raddr = AW'(in_data.read_index);

  lmtd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (PATH_DEPTH)
  ) u_path_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
      fwd_data <= ram_wdata;
    end
  end

  // Sensor classification for the item in the input register.
  logic              left_dark, right_dark, center_dark;
  logic [TIME_W-1:0] elapsed_ms;
  logic              goal_reached;
  logic [CODE_W-1:0] sense_decision;
  logic              append_req;
  logic [CODE_W-1:0] append_code;
  logic              store_full;

  assign left_dark   = a_item.sensor_0 > dark_threshold;
  assign right_dark  = a_item.sensor_5 > dark_threshold;
  assign center_dark = (a_item.sensor_1 > dark_threshold) ||
                       (a_item.sensor_2 > dark_threshold) ||
                       (a_item.sensor_3 > dark_threshold) ||
                       (a_item.sensor_4 > dark_threshold);
  assign elapsed_ms  = a_item.time_ms - crossing_start_ms;
  assign goal_reached = checking_crossing && left_dark && right_dark &&
                        (elapsed_ms > TIME_W'(goal_timeout_ms));
  assign store_full  = stored_count == CW'(PATH_DEPTH);

  always_comb begin
    checking_crossing_next = checking_crossing;
    left_branch_seen_next  = left_branch_seen || left_dark;
    right_branch_seen_next = right_branch_seen || right_dark;
    crossing_start_ms_next = crossing_start_ms;
    sense_decision         = DEC_CHECKING;
    append_req             = 1'b0;
    append_code            = DEC_DEAD_END;

    if (goal_reached) begin
      // The crossing stays pending and nothing is stored.
      sense_decision = DEC_GOAL;
    end else if (left_dark || right_dark) begin
      sense_decision = DEC_CHECKING;
      if (!checking_crossing) begin
        crossing_start_ms_next = a_item.time_ms;
        checking_crossing_next = 1'b1;
      end
    end else if (checking_crossing) begin
      // Leaving the crossing: left first, then straight, then right. With
      // nothing seen at all, the pick falls back to straight.
      if (left_branch_seen) begin
        append_code = DEC_LEFT;
      end else if (center_dark) begin
        append_code = DEC_STRAIGHT;
      end else if (right_branch_seen) begin
        append_code = DEC_RIGHT;
      end else begin
        append_code = DEC_STRAIGHT;
      end
      sense_decision         = append_code;
      append_req             = 1'b1;
      checking_crossing_next = 1'b0;
      left_branch_seen_next  = 1'b0;
      right_branch_seen_next = 1'b0;
    end else if (center_dark) begin
      sense_decision = DEC_STRAIGHT;
    end else begin
      sense_decision = DEC_DEAD_END;
      append_req     = 1'b1;
      append_code    = DEC_DEAD_END;
    end
  end

  // State and store updates happen only when a sense transaction leaves the
  // input register.
  logic sense_fire;

  assign sense_fire = a_fire && (a_item.opcode == OP_SENSE);
  assign ram_we     = sense_fire && append_req && !store_full;
  assign ram_waddr  = stored_count[AW-1:0];
  assign ram_wdata  = append_code;

  always_comb begin
    stored_count_next  = stored_count;
    overflow_flag_next = overflow_flag;
    if (append_req) begin
      if (store_full) begin
        overflow_flag_next = 1'b1;
      end else begin
        stored_count_next = stored_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checking_crossing <= 1'b0;
      left_branch_seen  <= 1'b0;
      right_branch_seen <= 1'b0;
      crossing_start_ms <= '0;
      stored_count      <= '0;
      overflow_flag     <= 1'b0;
    end else if (sense_fire) begin
      checking_crossing <= checking_crossing_next;
      left_branch_seen  <= left_branch_seen_next;
      right_branch_seen <= right_branch_seen_next;
      crossing_start_ms <= crossing_start_ms_next;
      stored_count      <= stored_count_next;
      overflow_flag     <= overflow_flag_next;
    end
  end

  // Read lookup: only entries below the count are returned, all others read
  // as zero.
  logic              read_hit;
  logic [CODE_W-1:0] read_value;

  assign read_hit   = CMP_W'(a_item.read_index) < CMP_W'(stored_count);
  assign read_value = fwd_hit ? fwd_data : ram_rdata;

  // Result assembly and the result register.
  lmtd_out_t result;

  always_comb begin
    result = '0;
    if (a_item.opcode == OP_READ) begin
      result.decision      = DEC_CHECKING;
      result.read_entry    = read_hit ? read_value : DEC_CHECKING;
      result.path_length   = PATH_LEN_W'(stored_count);
      result.path_overflow = overflow_flag;
    end else begin
      result.decision      = sense_decision;
      result.read_entry    = DEC_CHECKING;
      result.path_length   = PATH_LEN_W'(stored_count_next);
      result.path_overflow = overflow_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_data <= result;
    end
  end

endmodule

// File: hw/rtl/lmtd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/line_maze_turn_decider_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line maze turn decider testbench
// Drives sensor and read transactions through the decider under several
// threshold and timeout settings, predicts every result in step with the
// stimulus and compares each returned result field by field.
// ----------------------------------------------------------------------------
module line_maze_turn_decider_tb;
  import lmtd_pkg::*;

  // Clock, reset and all block inputs start at known values.
  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lmtd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lmtd_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Transactions waiting to be sent, and results predicted but not yet seen.
  lmtd_in_t maze_items[$];
  lmtd_out_t due_results[$];

  // Idle rates in percent for the sending and receiving side, and a hold that
  // stops the sender so the block can be emptied in the middle of a phase.
  int send_pct = 30;
  int recv_pct = 69;
  bit hold = 1'b0;

  // Our own copy of the block's registers and state.
  logic [SAMPLE_W-1:0] thr_cfg = DARK_THRESHOLD_RESET;
  logic [TIMEOUT_W-1:0] tmo_cfg = GOAL_TIMEOUT_MS_RESET;
  logic crossing = 1'b0;
  logic left_seen = 1'b0;
  logic right_seen = 1'b0;
  logic [TIME_W-1:0] cross_start = '0;
  logic [CODE_W-1:0] turn_mem[PATH_DEPTH_DEFAULT];
  logic [PATH_LEN_W-1:0] path_cnt = '0;
  logic ovf = 1'b0;

  // Running timestamp used while building sensor sequences.
  logic [TIME_W-1:0] gen_time = '0;

  int err_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_goal = 0;
  int n_read = 0;
  int n_cfg = 0;

  line_maze_turn_decider dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A fixed ceiling on the run. It is far above the slowest correct run, even
  // with heavy stalling.
  initial begin
    #4000000;
    $display("line_maze_turn_decider_tb: done, errors");
    $finish;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Adds one transaction to the end of the send queue.
  function automatic void queue_item(lmtd_in_t it);
    maze_items = {maze_items, it};
  endfunction

  // Appends one turn to the path store, or flags the overflow when full.
  function automatic void record_turn(logic [CODE_W-1:0] code);
    if (path_cnt < PATH_DEPTH_DEFAULT) begin
      turn_mem[path_cnt[INDEX_W-1:0]] = code;
      path_cnt++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  // Works out the result of one accepted transaction and advances the
  // crossing state, the way the left-hand rule decider is meant to behave.
  function automatic lmtd_out_t decide_turn(lmtd_in_t it);
    lmtd_out_t res;
    logic lft, ctr, rgt;
    logic [TIME_W-1:0] elapsed;
    logic [CODE_W-1:0] pick;
    res = '0;
    if (it.opcode == OP_READ) begin
      // Entries at or above the count read back as zero.
      if (it.read_index < path_cnt) begin
        res.read_entry = turn_mem[it.read_index];
      end
    end else begin
      lft = it.sensor_0 > thr_cfg;
      rgt = it.sensor_5 > thr_cfg;
      ctr = (it.sensor_1 > thr_cfg) || (it.sensor_2 > thr_cfg) ||
            (it.sensor_3 > thr_cfg) || (it.sensor_4 > thr_cfg);
      elapsed = it.time_ms - cross_start;
      // The branch flags latch on every sensor step, goal steps included.
      if (lft) begin
        left_seen = 1'b1;
      end
      if (rgt) begin
        right_seen = 1'b1;
      end
      if (crossing && lft && rgt && elapsed > TIME_W'(tmo_cfg)) begin
        // Goal keeps the crossing open and stores nothing.
        res.decision = DEC_GOAL;
      end else if (lft || rgt) begin
        // The goal timer starts only on the first branch step of a crossing.
        if (!crossing) begin
          cross_start = it.time_ms;
          crossing = 1'b1;
        end
        res.decision = DEC_CHECKING;
      end else if (crossing) begin
        // Leaving the crossing: left first, then straight, then right.
        if (left_seen) begin
          pick = DEC_LEFT;
        end else if (ctr) begin
          pick = DEC_STRAIGHT;
        end else if (right_seen) begin
          pick = DEC_RIGHT;
        end else begin
          pick = DEC_STRAIGHT;
        end
        crossing = 1'b0;
        left_seen = 1'b0;
        right_seen = 1'b0;
        record_turn(pick);
        res.decision = pick;
      end else if (ctr) begin
        res.decision = DEC_STRAIGHT;
      end else begin
        record_turn(DEC_DEAD_END);
        res.decision = DEC_DEAD_END;
      end
    end
    res.path_length = path_cnt;
    res.path_overflow = ovf;
    return res;
  endfunction

  // Driver. It records each accepted transaction with its predicted result,
  // then presents the next one unless the sender idles or is held. A stalled
  // transaction stays on the bus unchanged.
  always @(posedge clk) begin : drv
    lmtd_out_t pred;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = decide_turn(in_data);
        due_results = {due_results, pred};
        n_sent++;
        if (in_data.opcode == OP_READ) begin
          n_read++;
        end
        if (pred.decision == DEC_GOAL && in_data.opcode == OP_SENSE) begin
          n_goal++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (!hold && maze_items.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          in_data <= maze_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result is compared with the oldest prediction,
  // and the stall for the next cycle is drawn at random.
  always @(posedge clk) begin : mon
    lmtd_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %p arrived with nothing expected", out_data));
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (out_data.decision !== want.decision) begin
            report_mismatch($sformatf("decision %0d, expected %0d",
                                      out_data.decision, want.decision));
          end
          if (out_data.read_entry !== want.read_entry) begin
            report_mismatch($sformatf("read_entry %0d, expected %0d",
                                      out_data.read_entry, want.read_entry));
          end
          if (out_data.path_length !== want.path_length) begin
            report_mismatch($sformatf("path_length %0d, expected %0d",
                                      out_data.path_length, want.path_length));
          end
          if (out_data.path_overflow !== want.path_overflow) begin
            report_mismatch($sformatf("path_overflow %0d, expected %0d",
                                      out_data.path_overflow, want.path_overflow));
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Returns a sample on the requested side of the threshold. One draw in eight
  // lands right on the boundary, where equal to the threshold still reads light.
  function automatic logic [SAMPLE_W-1:0] pick_sample(bit dark);
    if (dark) begin
      if (thr_cfg == 12'hFFF) begin
        return 12'hFFF;
      end
      if ($urandom_range(0, 7) == 0) begin
        return thr_cfg + 12'd1;
      end
      return 12'($urandom_range(4095, int'(thr_cfg) + 1));
    end
    if ($urandom_range(0, 7) == 0) begin
      return thr_cfg;
    end
    return 12'($urandom_range(int'(thr_cfg), 0));
  endfunction

  // Builds a sensor transaction from left, center and right darkness. A dark
  // center darkens a random nonempty subset of the four middle sensors.
  function automatic lmtd_in_t sense_item(bit l, bit c, bit r, logic [TIME_W-1:0] t);
    lmtd_in_t it;
    logic [3:0] cm;
    cm = c ? 4'($urandom_range(15, 1)) : 4'd0;
    it.opcode = OP_SENSE;
    it.sensor_0 = pick_sample(l);
    it.sensor_1 = pick_sample(cm[0]);
    it.sensor_2 = pick_sample(cm[1]);
    it.sensor_3 = pick_sample(cm[2]);
    it.sensor_4 = pick_sample(cm[3]);
    it.sensor_5 = pick_sample(r);
    it.time_ms = t;
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic lmtd_in_t raw_sense(logic [SAMPLE_W-1:0] s0, s1, s2, s3, s4, s5,
                                         logic [TIME_W-1:0] t);
    lmtd_in_t it;
    it.opcode = OP_SENSE;
    it.sensor_0 = s0;
    it.sensor_1 = s1;
    it.sensor_2 = s2;
    it.sensor_3 = s3;
    it.sensor_4 = s4;
    it.sensor_5 = s5;
    it.time_ms = t;
    it.read_index = 8'($urandom);
    return it;
  endfunction

  // A read carries random sensor and time fields, which the block ignores.
  function automatic lmtd_in_t read_item(logic [INDEX_W-1:0] idx);
    logic [127:0] raw;
    lmtd_in_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(lmtd_in_t)-1:0];
    it.opcode = OP_READ;
    it.read_index = idx;
    return it;
  endfunction

  // Advances the running timestamp: mostly small steps, sometimes steps near
  // the goal timeout, and now and then a jump anywhere, which wraps the clock.
  function automatic logic [TIME_W-1:0] next_time();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel < 7) begin
      gen_time += 32'($urandom_range(60, 0));
    end else if (sel < 9) begin
      gen_time += 32'($urandom_range(2 * int'(tmo_cfg) + 2, 0));
    end else begin
      gen_time += $urandom;
    end
    return gen_time;
  endfunction

  // One stretch of maze: a little line following, then a crossing, a dead
  // end, a path read or a random transaction. Crossings sometimes dwell on
  // both branches long enough to report the goal, or exactly up to the timeout.
  task automatic add_episode();
    int kind;
    bit lb, rb, lnow, rnow;
    logic [127:0] raw;
    lmtd_in_t it;
    repeat ($urandom_range(3, 0)) begin
      queue_item(sense_item(1'b0, 1'b1, 1'b0, next_time()));
    end
    kind = $urandom_range(99, 0);
    if (kind < 60) begin
      lb = 1'($urandom_range(1, 0));
      rb = 1'($urandom_range(1, 0));
      if (!lb && !rb) begin
        if ($urandom_range(1, 0) == 1) begin
          lb = 1'b1;
        end else begin
          rb = 1'b1;
        end
      end
      repeat ($urandom_range(3, 1)) begin
        lnow = lb && ($urandom_range(2, 0) != 0);
        rnow = rb && ($urandom_range(2, 0) != 0);
        if (!lnow && !rnow) begin
          lnow = lb;
          rnow = rb;
        end
        queue_item(sense_item(lnow, 1'($urandom_range(1, 0)), rnow, next_time()));
      end
      if ($urandom_range(2, 0) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          gen_time += 32'(tmo_cfg) + 32'($urandom_range(2, 0));
          queue_item(sense_item(1'b1, 1'($urandom_range(1, 0)), 1'b1, gen_time));
        end
      end
      queue_item(sense_item(1'b0, 1'($urandom_range(1, 0)), 1'b0, next_time()));
    end else if (kind < 75) begin
      queue_item(sense_item(1'b0, 1'b0, 1'b0, next_time()));
    end else if (kind < 88) begin
      if ($urandom_range(1, 0) == 1) begin
        queue_item(read_item(8'($urandom_range(15, 0))));
      end else begin
        queue_item(read_item(8'($urandom)));
      end
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(lmtd_in_t)-1:0];
      queue_item(it);
    end
  endtask

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx == REG_DARK_THRESHOLD) begin
      thr_cfg = val[SAMPLE_W-1:0];
    end else begin
      tmo_cfg = val;
    end
    n_cfg++;
  endtask

  // Waits until everything sent has come back, plus a margin for the two
  // register stages.
  task automatic drain();
    while (maze_items.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // One phase: set both registers, queue about n transactions, and halfway
  // through hold the sender until every outstanding result has come back.
  task automatic run_phase(logic [SAMPLE_W-1:0] thr, logic [TIMEOUT_W-1:0] tmo, int n,
                           int s_pct, int r_pct);
    write_reg(REG_DARK_THRESHOLD, {4'($urandom), thr});
    write_reg(REG_GOAL_TIMEOUT_MS, tmo);
    send_pct = s_pct;
    recv_pct = r_pct;
    while (maze_items.size() < n) begin
      add_episode();
    end
    while (maze_items.size() > n / 2) begin
      @(posedge clk);
    end
    hold = 1'b1;
    @(posedge clk);
    while (in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    hold = 1'b0;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under the reset settings (threshold 2048, 500 ms).
    // Line following, an all-light view and a view exactly at the threshold
    // both give dead ends.
    queue_item(raw_sense(12'd0, 12'd3000, 12'd0, 12'd0, 12'd0, 12'd0, 32'd10));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd20));
    queue_item(raw_sense(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048,
                         12'd2048, 32'd30));
    // Left branch just above the threshold opens a crossing; both branches at
    // exactly the timeout still check, one millisecond later is the goal, and
    // leaving picks left.
    queue_item(raw_sense(12'd2049, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd100));
    queue_item(raw_sense(12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 32'd600));
    queue_item(raw_sense(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                         32'd601));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd2049, 12'd0, 32'd610));
    // Right branch with the line ahead goes straight; without it, right.
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd2049, 32'd700));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd3000, 12'd0, 12'd0, 32'd710));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 32'd720));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd730));
    queue_item(raw_sense(12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0, 12'd0, 32'd740));
    // Reads of stored turns, one at the count and one at the top index.
    queue_item(read_item(8'd0));
    queue_item(read_item(8'd2));
    queue_item(read_item(8'd3));
    queue_item(read_item(8'd4));
    queue_item(read_item(8'd5));
    queue_item(read_item(8'd255));
    // A goal timer that runs across the wrap of the millisecond clock.
    queue_item(raw_sense(12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF,
                         32'hFFFF_FF00));
    queue_item(raw_sense(12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF,
                         32'h0000_0100));
    queue_item(raw_sense(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                         32'h0000_0110));
    gen_time = 32'h0000_0200;
    drain();

    // Sender idles 30 percent and receiver 69 percent of the cycles.
    run_phase(12'd0, 16'd0, 250, 30, 69);
    run_phase(12'hFFF, 16'hFFFF, 60, 30, 69);
    run_phase(12'($urandom), 16'($urandom_range(2000, 0)), 300, 30, 69);
    // The other way round.
    run_phase(12'($urandom_range(3800, 200)), 16'hFFFF, 300, 69, 30);
    run_phase(12'($urandom), 16'($urandom), 300, 69, 30);
    // Back to back, no idling on either side.
    run_phase(DARK_THRESHOLD_RESET, GOAL_TIMEOUT_MS_RESET, 300, 0, 0);
    run_phase(12'($urandom), 16'd1, 240, 0, 0);

    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    end
    $display("Run covered %0d transactions in, %0d results compared, %0d register writes.",
             n_sent, n_checked, n_cfg);
    $display("It saw %0d goals and %0d path reads; %0d turns stored, overflow %0d.",
             n_goal, n_read, path_cnt, ovf);
    if (err_cnt == 0) begin
      $display("line_maze_turn_decider_tb: done, clean");
    end else begin
      $display("line_maze_turn_decider_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: line_maze_turn_decider.f
hw/rtl/lmtd_pkg.sv
hw/rtl/lmtd_ram.sv
hw/rtl/line_maze_turn_decider.sv
tb/line_maze_turn_decider_tb.sv
